>>> design/manchester_pulse_width_decoder_top_macros.svh
// Assertion macros for the Manchester pulse-width decoder checker.
// Expects clk and rst to be visible where the macros are used.
`ifndef MANCHESTER_PULSE_WIDTH_DECODER_TOP_MACROS_SVH
`define MANCHESTER_PULSE_WIDTH_DECODER_TOP_MACROS_SVH

// clocked check, switched off while reset is high
`define MPWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define MPWD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/mpwd_pkg.sv
// Shared types and constants for the Manchester pulse-width decoder.
// No dependencies.
package mpwd_pkg;

  localparam int HALF_MAX_BITS  = 15;
  localparam int QUOTA_BITS     = 10;
  localparam int CFG_DATA_BITS  = 15;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [HALF_MAX_BITS-1:0] HALF_MAX_RESET = 15'd750;
  localparam logic [QUOTA_BITS-1:0]    QUOTA_RESET    = 10'd0;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_MAX = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUOTA    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_FRAME    = 2'd1,
    ST_OUT_OF_SYNC = 2'd2
  } status_t;

  // one decode step: what the step unit is told
  typedef struct packed {
    logic full;       // interval at or above the half limit
    logic last;       // final interval of the segment
    logic first;      // first interval decoded after frame start
    logic awaiting;   // a half is waiting for its second half
    logic parity;     // index parity of this interval
    logic count_ok;   // bit count has reached the bit quota
  } step_in_t;

  // ... and what it decides
  typedef struct packed {
    logic    emit_bit;
    logic    bit_val;
    logic    finish;
    status_t status;
    logic    awaiting;
  } step_out_t;

endpackage

>>> design/mpwd_if.sv
// Valid/ready channel interfaces for the Manchester pulse-width decoder.
// Input channel carries one interval; output channel carries one result.
interface mpwd_in_if #(
  parameter int DURATION_BITS = 15
);
  logic                     valid;
  logic                     ready;
  logic [DURATION_BITS-1:0] duration;
  logic                     last_interval;

  modport source (output valid, duration, last_interval, input ready);
  modport sink   (input valid, duration, last_interval, output ready);
endinterface

interface mpwd_out_if #(
  parameter int COUNT_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  bit_value;
  logic                  is_report;
  logic [1:0]            status;
  logic [COUNT_BITS-1:0] bits_decoded;
  logic                  last_of_run;

  modport source (output valid, bit_value, is_report, status, bits_decoded, last_of_run,
                  input ready);
  modport sink   (input valid, bit_value, is_report, status, bits_decoded, last_of_run,
                  output ready);
endinterface

>>> design/mpwd_ram.sv
// Interval buffer: one write port, one read port, registered read data.
// No dependencies.
module mpwd_ram #(
  parameter  int DEPTH     = 32,
  parameter  int WIDTH     = 15,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/mpwd_step.sv
// Decode step for one interval: bit, stop and pairing decisions.
// Depends on mpwd_pkg.
module mpwd_step (
  input  mpwd_pkg::step_in_t  si,
  output mpwd_pkg::step_out_t so
);
  import mpwd_pkg::*;

  always_comb begin
    so.emit_bit = 1'b0;
    so.bit_val  = 1'b0;
    so.finish   = 1'b0;
    so.status   = ST_OK;
    so.awaiting = 1'b0;
    if (si.awaiting) begin
      // second half: a full one ends the frame, out of sync below the bit quota
      if (si.full) begin
        so.finish = 1'b1;
        so.status = si.count_ok ? ST_OK : ST_OUT_OF_SYNC;
      end else if (si.last) begin
        so.finish = 1'b1;
      end
    end else if (si.last && !si.first) begin
      so.finish = 1'b1;
    end else begin
      so.emit_bit = 1'b1;
      so.bit_val  = si.parity ^ si.full;
      if (si.last) begin
        so.finish = 1'b1;
      end else begin
        so.awaiting = !si.full;
      end
    end
  end

endmodule

>>> design/manchester_pulse_width_decoder_top.sv
// Manchester pulse-width decoder, top level: sequencer, config registers, output register.
// Depends on mpwd_pkg, mpwd_if, mpwd_ram and mpwd_step.
//
//   channel  dir  handshake         payload
//   in_ch    in   valid/ready       duration, last_interval
//   out_ch   out  valid/ready       bit_value, is_report, status, bits_decoded, last_of_run
//   cfg      in   cfg_we (no wait)  cfg_index, cfg_data
//
// An ordinary interval is transferred, then decoded in C_ITEM; a bit that ends the
// segment is followed by its report in C_REPORT.
// The interval that marks frame start adds its leading bits and a replay of the
// buffer, each entry read in C_FETCH and then decoded in C_REPLAY; the registered
// read port of the buffer sets this split.
// Reset is synchronous; the buffer needs no clearing, as only entries written in
// the current segment are replayed. A stalled output holds the sequencer in place.
module manchester_pulse_width_decoder_top #(
  parameter int SEARCH_WINDOW = 32,
  parameter int DURATION_BITS = 15,
  parameter int COUNT_BITS    = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  mpwd_in_if.sink                                in_ch,
  mpwd_out_if.source                             out_ch,
  input  logic                                   cfg_we,
  input  logic [mpwd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [mpwd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import mpwd_pkg::*;

  localparam int POS_BITS = $clog2(SEARCH_WINDOW);
  localparam int CMP_W    = (DURATION_BITS > HALF_MAX_BITS) ? DURATION_BITS : HALF_MAX_BITS;
  localparam int CNT_W    = (COUNT_BITS > QUOTA_BITS) ? COUNT_BITS : QUOTA_BITS;
  localparam logic [POS_BITS-1:0]   POS_LAST  = POS_BITS'(SEARCH_WINDOW - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // sequencer states
  typedef enum logic [2:0] {
    C_IDLE,    // ready for a transfer
    C_ITEM,    // act on the captured interval
    C_LEAD1,   // second leading bit when the first interval is long
    C_FETCH,   // buffer read in flight
    C_REPLAY,  // decode one buffered interval
    C_REPORT   // end-of-segment report after a bit
  } ctl_t;

  // where the segment stands
  typedef enum logic [1:0] {
    SG_SEARCH,
    SG_FIRST,
    SG_DECODE,
    SG_DONE
  } seg_t;

  ctl_t                     state;
  seg_t                     seg;
  logic [DURATION_BITS-1:0] d_reg;
  logic                     last_reg;
  logic [POS_BITS-1:0]      position;
  logic [POS_BITS-1:0]      k;
  logic                     awaiting;
  logic                     parity;
  logic [COUNT_BITS-1:0]    bit_count;
  status_t                  rep_status;
  logic [HALF_MAX_BITS-1:0] half_max;
  logic [QUOTA_BITS-1:0]    bit_quota;

  // output register
  logic                  out_valid;
  logic                  ob_bit;
  logic                  ob_rep;
  status_t               ob_status;
  logic [COUNT_BITS-1:0] ob_count;
  logic                  ob_last;

  logic [DURATION_BITS-1:0] rdata;
  logic [DURATION_BITS-1:0] cur_d;
  logic                     in_fire;
  logic                     out_free;
  logic                     final_k;
  logic                     long_in;
  logic                     stepping;
  logic [COUNT_BITS-1:0]    count_inc;
  step_in_t                 si;
  step_out_t                so;

  assign in_ch.ready = (state == C_IDLE);
  assign in_fire     = in_ch.valid && (state == C_IDLE);
  assign out_free    = !out_valid || out_ch.ready;

  assign out_ch.valid        = out_valid;
  assign out_ch.bit_value    = ob_bit;
  assign out_ch.is_report    = ob_rep;
  assign out_ch.status       = ob_status;
  assign out_ch.bits_decoded = ob_count;
  assign out_ch.last_of_run  = ob_last;

  // intervals are buffered only during the frame-start search
  mpwd_ram #(
    .DEPTH (SEARCH_WINDOW),
    .WIDTH (DURATION_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (in_fire && (seg == SG_SEARCH)),
    .waddr (position),
    .wdata (DURATION_BITS'(in_ch.duration)),
    .raddr (k),
    .rdata (rdata)
  );

  // live interval, or the buffered one during replay
  assign cur_d     = (state == C_REPLAY) ? rdata : d_reg;
  assign final_k   = (state == C_ITEM) || (k == position);
  assign long_in   = CMP_W'(d_reg) > CMP_W'(half_max);
  assign count_inc = (bit_count == COUNT_MAX) ? bit_count : bit_count + 1'b1;
  assign stepping  = (state == C_REPLAY) ||
                     ((state == C_ITEM) && ((seg == SG_FIRST) || (seg == SG_DECODE)));

  always_comb begin
    si.full     = CMP_W'(cur_d) >= CMP_W'(half_max);
    si.last     = last_reg && final_k;
    si.first    = (seg == SG_FIRST);
    si.awaiting = awaiting;
    si.parity   = parity;
    si.count_ok = CNT_W'(bit_count) >= CNT_W'(bit_quota);
  end

  mpwd_step u_step (
    .si (si),
    .so (so)
  );

  always_ff @(posedge clk) begin : seq
    logic done;
    done = 1'b0;
    if (rst) begin
      state     <= C_IDLE;
      seg       <= SG_SEARCH;
      position  <= '0;
      k         <= '0;
      awaiting  <= 1'b0;
      parity    <= 1'b0;
      bit_count <= '0;
      out_valid <= 1'b0;
      half_max  <= HALF_MAX_RESET;
      bit_quota <= QUOTA_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_MAX: half_max  <= HALF_MAX_BITS'(cfg_data);
          REG_QUOTA:    bit_quota <= QUOTA_BITS'(cfg_data);
          default: ;
        endcase
      end

      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (stepping) begin
        if (!so.emit_bit && !so.finish) begin
          // a second half that pairs up quietly
          awaiting <= so.awaiting;
          parity   <= !parity;
          seg      <= SG_DECODE;
          if (final_k) begin
            done = 1'b1;
          end else begin
            k     <= k + 1'b1;
            state <= C_FETCH;
          end
        end else if (out_free) begin
          awaiting  <= so.awaiting;
          parity    <= !parity;
          seg       <= SG_DECODE;
          out_valid <= 1'b1;
          if (so.emit_bit) begin
            bit_count <= count_inc;
            ob_bit    <= so.bit_val;
            ob_rep    <= 1'b0;
            ob_status <= ST_OK;
            ob_count  <= count_inc;
            ob_last   <= final_k && !so.finish;
            if (so.finish) begin
              rep_status <= so.status;
              state      <= C_REPORT;
            end else if (final_k) begin
              done = 1'b1;
            end else begin
              k     <= k + 1'b1;
              state <= C_FETCH;
            end
          end else begin
            ob_bit    <= 1'b0;
            ob_rep    <= 1'b1;
            ob_status <= so.status;
            ob_count  <= bit_count;
            ob_last   <= 1'b1;
            seg       <= SG_DONE;
            done = 1'b1;
          end
        end
      end else begin
        case (state)
          C_IDLE: begin
            if (in_fire) begin
              d_reg    <= DURATION_BITS'(in_ch.duration);
              last_reg <= in_ch.last_interval;
              state    <= C_ITEM;
            end
          end
          C_ITEM: begin
            if (seg == SG_SEARCH) begin
              if (long_in) begin
                // frame start: leading bit, then a second one (slot zero) or align and replay
                if (out_free) begin
                  out_valid <= 1'b1;
                  ob_bit    <= position[0];
                  ob_rep    <= 1'b0;
                  ob_status <= ST_OK;
                  ob_count  <= count_inc;
                  ob_last   <= 1'b0;
                  bit_count <= count_inc;
                  seg       <= SG_FIRST;
                  awaiting  <= 1'b0;
                  if (position == '0) begin
                    parity <= 1'b1;
                    state  <= C_LEAD1;
                  end else begin
                    parity <= position[0];
                    k      <= {{(POS_BITS-1){1'b0}}, position[0]};
                    state  <= C_FETCH;
                  end
                end
              end else if (last_reg || (position == POS_LAST)) begin
                if (out_free) begin
                  out_valid <= 1'b1;
                  ob_bit    <= 1'b0;
                  ob_rep    <= 1'b1;
                  ob_status <= ST_NO_FRAME;
                  ob_count  <= bit_count;
                  ob_last   <= 1'b1;
                  seg       <= SG_DONE;
                  done = 1'b1;
                end
              end else begin
                position <= position + 1'b1;
                state    <= C_IDLE;
              end
            end else begin
              // decoding stopped: the rest of the segment is dropped
              done = 1'b1;
            end
          end
          C_LEAD1: begin
            if (out_free) begin
              out_valid <= 1'b1;
              ob_bit    <= 1'b1;
              ob_rep    <= 1'b0;
              ob_status <= ST_OK;
              ob_count  <= count_inc;
              ob_last   <= !last_reg;
              bit_count <= count_inc;
              if (last_reg) begin
                rep_status <= ST_OK;
                state      <= C_REPORT;
              end else begin
                done = 1'b1;
              end
            end
          end
          C_FETCH: begin
            state <= C_REPLAY;
          end
          C_REPORT: begin
            if (out_free) begin
              out_valid <= 1'b1;
              ob_bit    <= 1'b0;
              ob_rep    <= 1'b1;
              ob_status <= rep_status;
              ob_count  <= bit_count;
              ob_last   <= 1'b1;
              seg       <= SG_DONE;
              done = 1'b1;
            end
          end
          default: begin
            state <= C_IDLE;
          end
        endcase
      end

      // item finished; a final interval starts a fresh segment
      if (done) begin
        state <= C_IDLE;
        if (last_reg) begin
          seg       <= SG_SEARCH;
          position  <= '0;
          awaiting  <= 1'b0;
          parity    <= 1'b0;
          bit_count <= '0;
        end
      end
    end
  end

endmodule

>>> design/mpwd_checker.sv
// Port-level checks for the Manchester pulse-width decoder, bound to the top level.
// Depends on manchester_pulse_width_decoder_top_macros.svh and mpwd_pkg.
`include "manchester_pulse_width_decoder_top_macros.svh"

module mpwd_checker #(
  parameter int COUNT_BITS = 10
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  bit_value,
  input logic                  is_report,
  input logic [1:0]            status,
  input logic [COUNT_BITS-1:0] bits_decoded,
  input logic                  last_of_run
);
  import mpwd_pkg::*;

  logic                  stalled;
  logic [COUNT_BITS+4:0] payload;

  assign stalled = out_valid && !out_ready;
  assign payload = {bit_value, is_report, status, bits_decoded, last_of_run};

  `MPWD_ASSERT_ALWAYS(a_rst_empties_out, rst |=> !out_valid, "output valid after reset")

  `MPWD_ASSERT(a_stall_holds, stalled |=> out_valid && $stable(payload), "stalled result changed")

  `MPWD_ASSERT(a_report_ends_run, out_valid && is_report |-> last_of_run, "report not last of run")

  `MPWD_ASSERT(a_bit_status_ok, out_valid && !is_report |-> status == ST_OK, "data bit with status")

  `MPWD_ASSERT(a_report_bit_zero, out_valid && is_report |-> !bit_value, "report with bit set")

endmodule

bind manchester_pulse_width_decoder_top mpwd_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_mpwd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .bit_value    (out_ch.bit_value),
  .is_report    (out_ch.is_report),
  .status       (out_ch.status),
  .bits_decoded (out_ch.bits_decoded),
  .last_of_run  (out_ch.last_of_run)
);

>>> tb/tb_manchester_pulse_width_decoder_top.sv
// Self-checking testbench for manchester_pulse_width_decoder_top.
// Uses mpwd_pkg, mpwd_in_if and mpwd_out_if from the design. It runs a
// directed table, then random segments under several register settings.
module tb_manchester_pulse_width_decoder_top;
  import mpwd_pkg::*;

  localparam int DUR_W   = 15;
  localparam int CNT_W   = 10;
  localparam int WINDOW  = 32;
  localparam int MAX_RUN = 34;
  // covers a frame-start replay of the whole window, with a margin on top
  localparam int SETTLE  = 100;
  localparam int DUR_MAX = (1 << DUR_W) - 1;

  typedef struct packed {
    logic             bit_value;
    logic             is_report;
    status_t          status;
    logic [CNT_W-1:0] bits_decoded;
    logic             last_of_run;
  } result_t;

  typedef enum logic [1:0] {DP_SEEK, DP_FIRST, DP_DECODE, DP_DONE} dec_phase_t;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // directed row: an interval (a = duration, b = last flag) or a register
  // write (a = index, b = data); the typed fields give the last result the
  // row should cause, where it is obvious
  typedef struct packed {
    row_kind_t        kind;
    logic [14:0]      a;
    logic [14:0]      b;
    logic [5:0]       reps;
    logic             typed;
    logic             t_rep;
    status_t          t_st;
    logic [CNT_W-1:0] t_cnt;
  } dir_row_t;

  localparam int N_ROWS = 27;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  mpwd_in_if  #(.DURATION_BITS(DUR_W)) in_ch ();
  mpwd_out_if #(.COUNT_BITS(CNT_W))    out_ch ();

  manchester_pulse_width_decoder_top #(
    .SEARCH_WINDOW(WINDOW),
    .DURATION_BITS(DUR_W),
    .COUNT_BITS   (CNT_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: own copy of the decoder state and of both registers
  // ---------------------------------------------------------------------
  logic [DUR_W-1:0] half_lim = HALF_MAX_RESET;
  logic [CNT_W-1:0] min_cnt  = QUOTA_RESET;

  dec_phase_t       phase     = DP_SEEK;
  int               seek_pos  = 0;
  logic [DUR_W-1:0] pre_buf [WINDOW];
  logic             want_second = 1'b0;
  logic             odd_slot  = 1'b0;
  logic [CNT_W-1:0] bit_count = '0;

  result_t run_q[$];   // results of the interval just taken
  result_t exp_q[$];   // results still owed by the block

  int err_cnt  = 0;
  int live_cnt = 0;    // intervals taken while not in the dead tail of a segment

  function automatic void emit(logic b, logic rep, status_t st);
    result_t r;
    if (run_q.size() >= MAX_RUN) return;
    r.bit_value    = b;
    r.is_report    = rep;
    r.status       = st;
    r.bits_decoded = bit_count;
    r.last_of_run  = 1'b0;
    run_q.push_back(r);
  endfunction

  function automatic void emit_bit(logic b);
    if (bit_count != '1) bit_count++;
    emit(b, 1'b0, ST_OK);
  endfunction

  function automatic void close_frame(status_t st);
    emit(1'b0, 1'b1, st);
    phase = DP_DONE;
  endfunction

  function automatic void decode_interval(logic [DUR_W-1:0] d, logic is_last);
    logic first_one;
    logic was_odd;
    logic half;
    first_one = (phase == DP_FIRST);
    was_odd   = odd_slot;
    phase     = DP_DECODE;
    odd_slot  = ~odd_slot;
    if (want_second) begin
      want_second = 1'b0;
      if (d >= half_lim)
        close_frame((bit_count >= min_cnt) ? ST_OK : ST_OUT_OF_SYNC);
      else if (is_last)
        close_frame(ST_OK);
      return;
    end
    if (is_last && !first_one) begin
      close_frame(ST_OK);
      return;
    end
    half = (d < half_lim);
    emit_bit((!was_odd) != half);
    if (is_last)
      close_frame(ST_OK);
    else if (half)
      want_second = 1'b1;
  endfunction

  // works out every result of one interval and queues them
  function automatic void predict_interval(logic [DUR_W-1:0] d, logic is_last);
    int pos;
    int start;
    run_q.delete();
    case (phase)
      DP_SEEK: begin
        pos = seek_pos;
        pre_buf[pos] = d;
        if (d > half_lim) begin
          // the long interval's slot fixes the bit alignment
          if (pos == 0) begin
            emit_bit(1'b0);
            emit_bit(1'b1);
            start = 1;
          end else if (pos % 2 == 1) begin
            emit_bit(1'b1);
            start = 1;
          end else begin
            emit_bit(1'b0);
            start = 0;
          end
          phase       = DP_FIRST;
          odd_slot    = start[0];
          want_second = 1'b0;
          for (int k = start; k <= pos && phase != DP_DONE; k++)
            decode_interval(pre_buf[k], is_last && k == pos);
          if (is_last && phase != DP_DONE) close_frame(ST_OK);
        end else if (is_last || pos + 1 >= WINDOW) begin
          close_frame(ST_NO_FRAME);
        end else begin
          seek_pos = pos + 1;
        end
      end
      DP_FIRST, DP_DECODE: decode_interval(d, is_last);
      default: ;
    endcase
    if (is_last) begin
      phase       = DP_SEEK;
      seek_pos    = 0;
      want_second = 1'b0;
      odd_slot    = 1'b0;
      bit_count   = '0;
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
    foreach (run_q[i]) exp_q.push_back(run_q[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic flag(input string msg);
    err_cnt++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // typed expectation travels with the interval, so it lines up with the
  // transfer that carries it
  logic             tag_typed = 1'b0;
  logic             tag_rep   = 1'b0;
  status_t          tag_st    = ST_OK;
  logic [CNT_W-1:0] tag_cnt   = '0;

  // Input transfers feed the predictor, output transfers are checked against
  // the oldest expectation. Both are sampled on the same edge, in one process.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        if (phase != DP_DONE) live_cnt++;
        predict_interval(in_ch.duration, in_ch.last_interval);
        if (tag_typed) begin
          if (run_q.size() == 0) begin
            flag("directed row caused no result");
          end else begin
            want = run_q[run_q.size()-1];
            check_field("directed is_report", want.is_report, tag_rep);
            check_field("directed status", want.status, tag_st);
            check_field("directed bits_decoded", want.bits_decoded, tag_cnt);
          end
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (exp_q.size() == 0) begin
          flag("result with nothing expected");
        end else begin
          want = exp_q.pop_front();
          check_field("bit_value", out_ch.bit_value, want.bit_value);
          check_field("is_report", out_ch.is_report, want.is_report);
          check_field("status", out_ch.status, want.status);
          check_field("bits_decoded", out_ch.bits_decoded, want.bits_decoded);
          check_field("last_of_run", out_ch.last_of_run, want.last_of_run);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  logic calm = 1'b0;   // no input gaps for the current segment
  int   seg_q[$];      // durations of the segment being built

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // at or below the limit: never counts as long in the search
  function automatic int short_dur();
    return $urandom_range(int'(half_lim), 0);
  endfunction

  function automatic int half_dur();
    if (half_lim == 0) return 0;
    return $urandom_range(int'(half_lim) - 1, 0);
  endfunction

  function automatic int long_dur();
    int hl;
    hl = half_lim;
    if (hl >= DUR_MAX) return DUR_MAX;
    if ($urandom_range(3, 0) == 0) return $urandom_range(DUR_MAX, hl + 1);
    return $urandom_range((2 * hl + 1 > DUR_MAX) ? DUR_MAX : 2 * hl + 1, hl + 1);
  endfunction

  // equal to the limit is a full once decoding runs
  function automatic int full_dur();
    int hl;
    hl = half_lim;
    if ($urandom_range(7, 0) == 0) return hl;
    return $urandom_range((2 * hl > DUR_MAX) ? DUR_MAX : 2 * hl, hl);
  endfunction

  function automatic void build_segment();
    int kind;
    int n;
    seg_q.delete();
    kind = $urandom_range(99, 0);
    if (kind < 70) begin
      // well-formed frame: short lead-in, long sync, Manchester symbols
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 0);
      repeat (n) seg_q.push_back(short_dur());
      seg_q.push_back(long_dur());
      repeat ($urandom_range(14, 0)) begin
        if ($urandom_range(1, 0) == 0) begin
          seg_q.push_back(full_dur());
        end else begin
          seg_q.push_back(half_dur());
          // now and then break the pair with a long second half
          seg_q.push_back(($urandom_range(11, 0) == 0) ? full_dur() : half_dur());
        end
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(10, 1)) seg_q.push_back($urandom_range(DUR_MAX, 0));
    end else if (kind < 95) begin
      // lead-in that may run past the search window
      repeat ($urandom_range(40, 28)) seg_q.push_back(short_dur());
      if ($urandom_range(1, 0) == 0) seg_q.push_back(long_dur());
    end else begin
      seg_q.push_back($urandom_range(DUR_MAX, 0));
    end
  endfunction

  // one interval: optional gap, then hold valid until the transfer
  task automatic send_interval(input int dur, input logic is_last, input logic typed,
                               input logic t_rep, input status_t t_st,
                               input logic [CNT_W-1:0] t_cnt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.duration      <= dur[DUR_W-1:0];
    in_ch.last_interval <= is_last;
    tag_typed           <= typed;
    tag_rep             <= t_rep;
    tag_st              <= t_st;
    tag_cnt             <= t_cnt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // wait for every owed result, then let any replay with no result run out
  task automatic drain();
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HALF_MAX) half_lim = val[DUR_W-1:0];
    else                     min_cnt  = val[CNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic random_phase(input int hl, input int mb, input int target);
    int base;
    in_ch.valid <= 1'b0;
    drain();
    write_reg(REG_HALF_MAX, hl);
    write_reg(REG_QUOTA, mb);
    base = live_cnt;
    while (live_cnt - base < target) begin
      build_segment();
      calm = ($urandom_range(4, 0) == 0);
      foreach (seg_q[i])
        send_interval(seg_q[i], i == seg_q.size() - 1, 1'b0, 1'b0, ST_OK, '0);
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Directed table (reset settings: half limit 750, bit quota 0)
  // ---------------------------------------------------------------------
  dir_row_t dir_rows [N_ROWS] = '{
    // long first interval that is also last: two lead bits and a report
    '{ROW_ITEM, 15'd32767, 15'd1, 6'd1,  1'b1, 1'b1, ST_OK,          10'd2},
    // segment ends while searching, shortest duration
    '{ROW_ITEM, 15'd0,     15'd1, 6'd1,  1'b1, 1'b1, ST_NO_FRAME,    10'd0},
    // equal to the limit is not long in the search; sync at an odd slot
    '{ROW_ITEM, 15'd750,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd751,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd300,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd300,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd1500,  15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    // last interval that is not the first decoded: report only
    '{ROW_ITEM, 15'd1500,  15'd1, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    // sync at an even slot, replay starts at slot zero
    '{ROW_ITEM, 15'd200,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd200,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd900,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd200,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    // second half equal to the limit is a full: early stop, count met
    '{ROW_ITEM, 15'd750,   15'd0, 6'd1,  1'b1, 1'b1, ST_OK,          10'd4},
    // dead tail of the segment
    '{ROW_ITEM, 15'd100,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd100,   15'd1, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    // segment ends on its long leading interval at an odd slot
    '{ROW_ITEM, 15'd100,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd2000,  15'd1, 6'd1,  1'b1, 1'b1, ST_OK,          10'd2},
    // a whole window without a long interval
    '{ROW_ITEM, 15'd100,   15'd0, 6'd32, 1'b1, 1'b1, ST_NO_FRAME,    10'd0},
    '{ROW_ITEM, 15'd5000,  15'd1, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    // last interval taken as a second half
    '{ROW_ITEM, 15'd900,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd300,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd300,   15'd1, 6'd1,  1'b1, 1'b1, ST_OK,          10'd3},
    // early stop below the bit count: out of sync
    '{ROW_CFG,  15'd1,     15'd1023, 6'd1, 1'b0, 1'b0, ST_OK,        10'd0},
    '{ROW_ITEM, 15'd900,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd300,   15'd0, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0},
    '{ROW_ITEM, 15'd800,   15'd0, 6'd1,  1'b1, 1'b1, ST_OUT_OF_SYNC, 10'd3},
    '{ROW_ITEM, 15'd1,     15'd1, 6'd1,  1'b0, 1'b0, ST_OK,          10'd0}
  };

  // ---------------------------------------------------------------------
  // Output side: ready runs and stalls of random length
  // ---------------------------------------------------------------------
  initial begin
    int run_len;
    int stall;
    int r;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      run_len = ($urandom_range(9, 0) == 0) ? $urandom_range(150, 40)
                                             : $urandom_range(12, 1);
      out_ch.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      r = $urandom_range(99, 0);
      if (r < 20)      stall = 0;
      else if (r < 85) stall = $urandom_range(3, 1);
      else if (r < 97) stall = $urandom_range(12, 4);
      else             stall = $urandom_range(40, 20);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    in_ch.valid         = 1'b0;
    in_ch.duration      = '0;
    in_ch.last_interval = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        in_ch.valid <= 1'b0;
        drain();
        write_reg(dir_rows[i].a[CFG_INDEX_BITS-1:0], dir_rows[i].b);
      end else begin
        for (int r = 0; r < dir_rows[i].reps; r++)
          send_interval(dir_rows[i].a, dir_rows[i].b[0],
                        dir_rows[i].typed && r == dir_rows[i].reps - 1,
                        dir_rows[i].t_rep, dir_rows[i].t_st, dir_rows[i].t_cnt);
      end
    end

    // random segments; register extremes included
    random_phase(750,   0,    50);
    random_phase(0,     1023, 30);
    random_phase(32767, 0,    25);
    random_phase(300,   4,    50);
    random_phase(4000,  25,   40);
    random_phase(1,     1,    30);
    random_phase(750,   1023, 30);

    in_ch.valid <= 1'b0;
    drain();
    if (err_cnt == 0)
      $display("tb_manchester_pulse_width_decoder_top OK");
    else
      $display("tb_manchester_pulse_width_decoder_top NOT OK");
    $finish;
  end

  // hard stop, well beyond the slowest legal run
  initial begin
    #40000000;
    $display("tb_manchester_pulse_width_decoder_top NOT OK");
    $finish;
  end

endmodule

>>> manchester_pulse_width_decoder_top.f
+incdir+design
design/mpwd_pkg.sv
design/mpwd_if.sv
design/mpwd_ram.sv
design/mpwd_step.sv
design/manchester_pulse_width_decoder_top.sv
design/mpwd_checker.sv
tb/tb_manchester_pulse_width_decoder_top.sv
